// ===== hdl/h2ssm_pkg.sv =====
// Shared types and constants for the HTTP/2 stream state unit.
// No dependencies; used by the register block and the core.
`timescale 1ns / 1ps

package h2ssm_pkg;

    localparam int ADDR_W = 3;
    localparam logic [0:0] REG_DIRECTION = 1'd0;

    localparam logic [1:0] DIR_INBOUND  = 2'd1;
    localparam logic [1:0] DIR_OUTBOUND = 2'd2;

    localparam logic [7:0] FT_DATA     = 8'd0;
    localparam logic [7:0] FT_HEADERS  = 8'd1;
    localparam logic [7:0] FT_PRIORITY = 8'd2;
    localparam logic [7:0] FT_RST      = 8'd3;
    localparam logic [7:0] FT_WINDOW   = 8'd8;

    localparam logic [0:0] CMD_FRAME = 1'b0;
    localparam logic [0:0] CMD_FORCE = 1'b1;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_HEADERS = 3'd1,
        EV_DATA    = 3'd2,
        EV_PROTO   = 3'd3,
        EV_CLOSED  = 3'd4
    } event_t;

    typedef enum logic [2:0] {
        CODE_IDLE    = 3'd0,
        CODE_RES_LOC = 3'd1,
        CODE_RES_REM = 3'd2,
        CODE_OPEN    = 3'd3,
        CODE_HC_LOC  = 3'd4,
        CODE_HC_REM  = 3'd5,
        CODE_CLOSED  = 3'd6
    } state_code_t;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_RES_LOC = 7'b0000010,
        ST_RES_REM = 7'b0000100,
        ST_OPEN    = 7'b0001000,
        ST_HC_LOC  = 7'b0010000,
        ST_HC_REM  = 7'b0100000,
        ST_CLOSED  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic inbound;
        logic outbound;
    } dir_t;

    function automatic state_t from_code(input logic [2:0] code);
        state_t st;
        case (code)
            CODE_IDLE:    st = ST_IDLE;
            CODE_RES_LOC: st = ST_RES_LOC;
            CODE_RES_REM: st = ST_RES_REM;
            CODE_OPEN:    st = ST_OPEN;
            CODE_HC_LOC:  st = ST_HC_LOC;
            CODE_HC_REM:  st = ST_HC_REM;
            default:      st = ST_CLOSED;
        endcase
        return st;
    endfunction

    function automatic logic [2:0] to_code(input state_t st);
        logic [2:0] code;
        case (st)
            ST_IDLE:    code = CODE_IDLE;
            ST_RES_LOC: code = CODE_RES_LOC;
            ST_RES_REM: code = CODE_RES_REM;
            ST_OPEN:    code = CODE_OPEN;
            ST_HC_LOC:  code = CODE_HC_LOC;
            ST_HC_REM:  code = CODE_HC_REM;
            default:    code = CODE_CLOSED;
        endcase
        return code;
    endfunction

endpackage

// ===== hdl/h2ssm_if.sv =====
// Request channel interfaces: frame requests in, stream results out.
// Depends on nothing but plain logic types.
`timescale 1ns / 1ps

interface h2ssm_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] ftype;
    logic [7:0] frame_flags;
    logic [2:0] new_state;

    modport source (output valid, output cmd, output ftype, output frame_flags,
                    output new_state, input ready);
    modport sink   (input valid, input cmd, input ftype, input frame_flags,
                    input new_state, output ready);
endinterface

interface h2ssm_out_if;
    logic       valid;
    logic       ready;
    logic       forward;
    logic [2:0] event_res;
    logic       final_frame;
    logic [2:0] stream_state;

    modport source (output valid, output forward, output event_res, output final_frame,
                    output stream_state, input ready);
    modport sink   (input valid, input forward, input event_res, input final_frame,
                    input stream_state, output ready);
endinterface

// ===== hdl/h2ssm_cfg.sv =====
// APB-style register block holding the stream direction.
// Depends on h2ssm_pkg.
`timescale 1ns / 1ps

module h2ssm_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [h2ssm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output h2ssm_pkg::dir_t             dir
);

    logic [1:0] direction_reg;
    logic [1:0] direction_next;
    logic       reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = paddr[h2ssm_pkg::ADDR_W-1:2] == h2ssm_pkg::REG_DIRECTION;

    always_comb
    begin
        direction_next = direction_reg;
        if (psel && penable && pwrite && reg_hit)
        begin
            direction_next = pwdata[1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 2'd0;
        end
        else
        begin
            direction_reg <= direction_next;
        end
    end

    assign prdata       = reg_hit ? {30'd0, direction_reg} : 32'd0;
    assign dir.inbound  = direction_reg == h2ssm_pkg::DIR_INBOUND;
    assign dir.outbound = direction_reg == h2ssm_pkg::DIR_OUTBOUND;

endmodule

// ===== hdl/h2ssm_core.sv =====
// Stream state core: input register, transition decode, state and result registers.
// Depends on h2ssm_pkg and the channel interfaces.
`timescale 1ns / 1ps

module h2ssm_core (
    input  logic                clk,
    input  logic                rst_n,
    input  h2ssm_pkg::dir_t     dir,
    h2ssm_in_if.sink            in_ch,
    h2ssm_out_if.source         out_ch
);

    logic                s1_valid_reg;
    logic                s1_cmd_reg;
    logic [7:0]          s1_type_reg;
    logic                s1_end_reg;
    logic [2:0]          s1_ns_reg;
    h2ssm_pkg::state_t   state_reg;
    h2ssm_pkg::state_t   state_next;
    logic                out_valid_reg;
    logic                fwd_reg;
    h2ssm_pkg::event_t   ev_reg;
    logic                fin_reg;
    logic [2:0]          code_reg;

    logic                fwd_next;
    h2ssm_pkg::event_t   ev_next;
    logic                fin_next;
    logic                advance;
    logic                in_take;
    logic                inb;
    logic                outb;
    logic                is_data;
    logic                is_hdr;
    logic                is_pri;
    logic                is_rst;
    logic                is_win;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || advance;
    assign in_take  = in_ch.valid && in_ch.ready;

    assign inb     = dir.inbound;
    assign outb    = dir.outbound;
    assign is_data = s1_type_reg == h2ssm_pkg::FT_DATA;
    assign is_hdr  = s1_type_reg == h2ssm_pkg::FT_HEADERS;
    assign is_pri  = s1_type_reg == h2ssm_pkg::FT_PRIORITY;
    assign is_rst  = s1_type_reg == h2ssm_pkg::FT_RST;
    assign is_win  = s1_type_reg == h2ssm_pkg::FT_WINDOW;

    always_comb
    begin
        state_next = state_reg;
        fwd_next   = 1'b0;
        ev_next    = h2ssm_pkg::EV_NONE;
        fin_next   = 1'b0;
        if (s1_cmd_reg == h2ssm_pkg::CMD_FORCE)
        begin
            state_next = h2ssm_pkg::from_code(s1_ns_reg);
        end
        else
        begin
            case (state_reg)
                h2ssm_pkg::ST_IDLE:
                begin
                    if (is_hdr)
                    begin
                        state_next = h2ssm_pkg::ST_OPEN;
                        fwd_next   = outb;
                        if (inb)
                        begin
                            ev_next = h2ssm_pkg::EV_HEADERS;
                        end
                    end
                    else if (is_pri)
                    begin
                        fwd_next = outb;
                    end
                    else
                    begin
                        state_next = h2ssm_pkg::ST_CLOSED;
                        ev_next    = h2ssm_pkg::EV_PROTO;
                    end
                end
                h2ssm_pkg::ST_RES_LOC:
                begin
                    if (is_rst)
                    begin
                        fwd_next   = outb;
                        state_next = h2ssm_pkg::ST_CLOSED;
                    end
                    else if (outb)
                    begin
                        if (is_hdr)
                        begin
                            fwd_next   = 1'b1;
                            state_next = h2ssm_pkg::ST_HC_REM;
                        end
                        else if (is_pri)
                        begin
                            fwd_next = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = h2ssm_pkg::ST_CLOSED;
                        ev_next    = h2ssm_pkg::EV_PROTO;
                    end
                end
                h2ssm_pkg::ST_RES_REM:
                begin
                    if (is_rst)
                    begin
                        fwd_next   = outb;
                        state_next = h2ssm_pkg::ST_CLOSED;
                    end
                    else if (is_pri || is_win)
                    begin
                        fwd_next = outb;
                    end
                    else if (inb && is_hdr)
                    begin
                        state_next = h2ssm_pkg::ST_HC_LOC;
                        ev_next    = h2ssm_pkg::EV_HEADERS;
                    end
                end
                h2ssm_pkg::ST_OPEN:
                begin
                    fwd_next = outb;
                    if (is_rst)
                    begin
                        state_next = h2ssm_pkg::ST_CLOSED;
                    end
                    else if (is_data)
                    begin
                        if (s1_end_reg)
                        begin
                            fin_next   = 1'b1;
                            state_next = inb ? h2ssm_pkg::ST_HC_REM : h2ssm_pkg::ST_HC_LOC;
                        end
                        if (inb)
                        begin
                            ev_next = h2ssm_pkg::EV_DATA;
                        end
                    end
                end
                h2ssm_pkg::ST_HC_LOC:
                begin
                    if (is_rst)
                    begin
                        fwd_next   = outb;
                        state_next = h2ssm_pkg::ST_CLOSED;
                    end
                    else if (inb)
                    begin
                        if (s1_end_reg)
                        begin
                            state_next = h2ssm_pkg::ST_CLOSED;
                        end
                    end
                    else if (is_win || is_pri)
                    begin
                        fwd_next = outb;
                    end
                end
                h2ssm_pkg::ST_HC_REM:
                begin
                    if (inb)
                    begin
                        if (!(is_win || is_pri || is_rst))
                        begin
                            state_next = h2ssm_pkg::ST_CLOSED;
                            ev_next    = h2ssm_pkg::EV_CLOSED;
                        end
                    end
                    else if (is_rst || (is_data && s1_end_reg))
                    begin
                        state_next = h2ssm_pkg::ST_CLOSED;
                        fwd_next   = outb;
                    end
                    else
                    begin
                        fwd_next = 1'b1;
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= h2ssm_pkg::ST_IDLE;
        end
        else
        begin
            if (in_ch.ready)
            begin
                s1_valid_reg <= in_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_cmd_reg  <= in_ch.cmd;
            s1_type_reg <= in_ch.ftype;
            s1_end_reg  <= in_ch.frame_flags[0];
            s1_ns_reg   <= in_ch.new_state;
        end
        if (advance)
        begin
            fwd_reg  <= fwd_next;
            ev_reg   <= ev_next;
            fin_reg  <= fin_next;
            code_reg <= h2ssm_pkg::to_code(state_next);
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.forward      = fwd_reg;
    assign out_ch.event_res    = ev_reg;
    assign out_ch.final_frame  = fin_reg;
    assign out_ch.stream_state = code_reg;

endmodule

// ===== hdl/http2_stream_state_machine_unit.sv =====
// Top level of the HTTP/2 stream state unit: register block plus state core.
// Depends on h2ssm_pkg, h2ssm_if, h2ssm_cfg and h2ssm_core.
//
// Usage:
//   in_ch carries one request per accepted valid/ready beat: either a frame
//   (cmd = frame, ftype, frame_flags) or a forced load of new_state.
//   out_ch returns exactly one result per request: forward, event_res,
//   final_frame and the stream_state after the request.
//   The APB port holds the direction register at address 0; write it only
//   while no request is in flight.
//   out_ch.valid rises after a request passes the input register, then the
//   result register, so the result is registered. Throughput is one request
//   per cycle while out_ch.ready is high, set by the single state register
//   that each request reads and updates.
//   When out_ch.ready is low the result register holds; one more request is
//   taken into the input register, after which in_ch.ready drops until the
//   result is taken.
//   Reset puts the stream in idle, direction to not set, both channels empty.
`timescale 1ns / 1ps

module http2_stream_state_machine_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [h2ssm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    h2ssm_in_if.sink                    in_ch,
    h2ssm_out_if.source                 out_ch
);

    h2ssm_pkg::dir_t dir;

    h2ssm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .dir     (dir)
    );

    h2ssm_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .dir    (dir),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule

// ===== hdl/h2ssm_checker.sv =====
// Port-level assertions for the HTTP/2 stream state unit, bound to the top level.
// Depends on h2ssm_pkg and http2_stream_state_machine_unit.
`timescale 1ns / 1ps

module h2ssm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       forward,
    input logic [2:0] event_res,
    input logic       final_frame,
    input logic [2:0] stream_state
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(forward) && $stable(event_res)
            && $stable(final_frame) && $stable(stream_state))
        else $error("result changed while stalled");

    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input back-pressured without an output stall");

    a_error_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == h2ssm_pkg::EV_PROTO || event_res == h2ssm_pkg::EV_CLOSED)
            |-> stream_state == h2ssm_pkg::CODE_CLOSED)
        else $error("error event without closed stream");

    a_final_half_closed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && final_frame |-> (stream_state == h2ssm_pkg::CODE_HC_LOC
            || stream_state == h2ssm_pkg::CODE_HC_REM))
        else $error("final frame without half-closed state");

    a_forward_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && forward |-> event_res == h2ssm_pkg::EV_NONE)
        else $error("forwarded request raised an event");

endmodule

bind http2_stream_state_machine_unit h2ssm_checker u_h2ssm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .forward      (out_ch.forward),
    .event_res    (out_ch.event_res),
    .final_frame  (out_ch.final_frame),
    .stream_state (out_ch.stream_state)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for http2_stream_state_machine_unit: drives frame and force requests,
// predicts each result with an in-house stream state model, and writes direction over APB.
// Depends on hdl/h2ssm_pkg.sv, hdl/h2ssm_if.sv and the unit RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_ITEMS = 78;
    localparam logic [h2ssm_pkg::ADDR_W-1:0] DIR_ADDR = {h2ssm_pkg::REG_DIRECTION, 2'b00};

    typedef struct packed {
        logic       cmd;
        logic [7:0] ftype;
        logic [7:0] frame_flags;
        logic [2:0] new_state;
    } stream_request_t;

    typedef struct packed {
        logic                   forward;
        h2ssm_pkg::event_t      event_res;
        logic                   final_frame;
        h2ssm_pkg::state_code_t stream_state;
    } stream_result_t;

    class stream_scoreboard;
        h2ssm_pkg::state_code_t stream_code;
        logic [1:0]             direction;
        stream_result_t         pending_results[$];
        int                     errors;

        function new();
            stream_code = h2ssm_pkg::CODE_IDLE;
            direction = 2'd0;
            errors = 0;
        endfunction

        function stream_result_t step_stream(stream_request_t r);
            stream_result_t         res;
            h2ssm_pkg::state_code_t st;
            logic                   inb;
            logic                   outb;
            logic                   eos;
            logic [7:0]             ft;
            inb = (direction == h2ssm_pkg::DIR_INBOUND);
            outb = (direction == h2ssm_pkg::DIR_OUTBOUND);
            eos = r.frame_flags[0];
            ft = r.ftype;
            st = stream_code;
            res.forward = 1'b0;
            res.event_res = h2ssm_pkg::EV_NONE;
            res.final_frame = 1'b0;
            if (r.cmd == h2ssm_pkg::CMD_FORCE)
            begin
                st = (r.new_state > h2ssm_pkg::CODE_CLOSED)
                     ? h2ssm_pkg::CODE_CLOSED : h2ssm_pkg::state_code_t'(r.new_state);
            end
            else
            begin
                case (st)
                    h2ssm_pkg::CODE_IDLE:
                    begin
                        if (ft == h2ssm_pkg::FT_HEADERS)
                        begin
                            st = h2ssm_pkg::CODE_OPEN;
                            if (inb)
                                res.event_res = h2ssm_pkg::EV_HEADERS;
                            res.forward = outb;
                        end
                        else if (ft == h2ssm_pkg::FT_PRIORITY)
                            res.forward = outb;
                        else
                        begin
                            st = h2ssm_pkg::CODE_CLOSED;
                            res.event_res = h2ssm_pkg::EV_PROTO;
                        end
                    end
                    h2ssm_pkg::CODE_RES_LOC:
                    begin
                        if (ft == h2ssm_pkg::FT_RST)
                        begin
                            res.forward = outb;
                            st = h2ssm_pkg::CODE_CLOSED;
                        end
                        else if (outb)
                        begin
                            if (ft == h2ssm_pkg::FT_HEADERS)
                            begin
                                res.forward = 1'b1;
                                st = h2ssm_pkg::CODE_HC_REM;
                            end
                            else if (ft == h2ssm_pkg::FT_PRIORITY)
                                res.forward = 1'b1;
                        end
                        else
                        begin
                            st = h2ssm_pkg::CODE_CLOSED;
                            res.event_res = h2ssm_pkg::EV_PROTO;
                        end
                    end
                    h2ssm_pkg::CODE_RES_REM:
                    begin
                        if (ft == h2ssm_pkg::FT_RST)
                        begin
                            res.forward = outb;
                            st = h2ssm_pkg::CODE_CLOSED;
                        end
                        else if (ft == h2ssm_pkg::FT_PRIORITY || ft == h2ssm_pkg::FT_WINDOW)
                            res.forward = outb;
                        else if (inb && ft == h2ssm_pkg::FT_HEADERS)
                        begin
                            st = h2ssm_pkg::CODE_HC_LOC;
                            res.event_res = h2ssm_pkg::EV_HEADERS;
                        end
                    end
                    h2ssm_pkg::CODE_OPEN:
                    begin
                        res.forward = outb;
                        if (ft == h2ssm_pkg::FT_RST)
                            st = h2ssm_pkg::CODE_CLOSED;
                        else if (ft == h2ssm_pkg::FT_DATA)
                        begin
                            if (eos)
                            begin
                                res.final_frame = 1'b1;
                                st = inb ? h2ssm_pkg::CODE_HC_REM : h2ssm_pkg::CODE_HC_LOC;
                            end
                            if (inb)
                                res.event_res = h2ssm_pkg::EV_DATA;
                        end
                    end
                    h2ssm_pkg::CODE_HC_LOC:
                    begin
                        if (ft == h2ssm_pkg::FT_RST)
                        begin
                            res.forward = outb;
                            st = h2ssm_pkg::CODE_CLOSED;
                        end
                        else if (inb)
                        begin
                            if (eos)
                                st = h2ssm_pkg::CODE_CLOSED;
                        end
                        else if (ft == h2ssm_pkg::FT_WINDOW || ft == h2ssm_pkg::FT_PRIORITY)
                            res.forward = outb;
                    end
                    h2ssm_pkg::CODE_HC_REM:
                    begin
                        if (inb)
                        begin
                            if (!(ft == h2ssm_pkg::FT_WINDOW || ft == h2ssm_pkg::FT_PRIORITY
                                  || ft == h2ssm_pkg::FT_RST))
                            begin
                                st = h2ssm_pkg::CODE_CLOSED;
                                res.event_res = h2ssm_pkg::EV_CLOSED;
                            end
                        end
                        else if (ft == h2ssm_pkg::FT_RST || (ft == h2ssm_pkg::FT_DATA && eos))
                        begin
                            st = h2ssm_pkg::CODE_CLOSED;
                            res.forward = outb;
                        end
                        else
                            res.forward = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            stream_code = st;
            res.stream_state = st;
            return res;
        endfunction

        function void note_request(stream_request_t r);
            pending_results.push_back(step_stream(r));
        endfunction

        function void report(string field, int exp_val, int act_val);
            errors++;
            if (errors <= 40)
                $display("%0t: %s expected %0d actual %0d", $time, field, exp_val, act_val);
        endfunction

        function void check_result(logic fwd, logic [2:0] ev, logic fin, logic [2:0] st);
            stream_result_t exp_res;
            if (pending_results.size() == 0)
            begin
                report("result with no request outstanding, stream_state", -1, st);
                return;
            end
            exp_res = pending_results.pop_front();
            if (fwd !== exp_res.forward)
                report("forward", exp_res.forward, fwd);
            if (ev !== exp_res.event_res)
                report("event_res", exp_res.event_res, ev);
            if (fin !== exp_res.final_frame)
                report("final_frame", exp_res.final_frame, fin);
            if (st !== exp_res.stream_state)
                report("stream_state", exp_res.stream_state, st);
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [h2ssm_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                  pwdata;
    logic [31:0]                  prdata;
    logic                         pready;
    int                           idle_cycles = 0;

    h2ssm_in_if  in_ch ();
    h2ssm_out_if out_ch ();

    stream_scoreboard sb = new();

    http2_stream_state_machine_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result sink: picks a random stall mode and holds it for a random run
    initial
    begin
        int stall_mode;
        int mode_left;
        int tick;
        stall_mode = 0;
        mode_left = 0;
        tick = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            tick++;
            case (stall_mode)
                0:       out_ch.ready = 1'b1;
                1:       out_ch.ready = ($urandom_range(0, 3) != 0);
                2:       out_ch.ready = ($urandom_range(0, 3) == 0);
                default: out_ch.ready = tick[2];
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.forward, out_ch.event_res, out_ch.final_frame,
                                out_ch.stream_state);
            if (in_ch.valid && in_ch.ready)
                sb.note_request({in_ch.cmd, in_ch.ftype, in_ch.frame_flags,
                                 in_ch.new_state});
            if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)
                || (psel && penable && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // caller is at a falling edge
    task automatic drive_request(input stream_request_t r);
        in_ch.valid = 1'b1;
        in_ch.cmd = r.cmd;
        in_ch.ftype = r.ftype;
        in_ch.frame_flags = r.frame_flags;
        in_ch.new_state = r.new_state;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic push_request(input logic c, input logic [7:0] ft, input logic [7:0] fl,
                                input logic [2:0] ns);
        @(negedge clk);
        drive_request({c, ft, fl, ns});
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_direction(input logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = DIR_ADDR;
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.direction = value[1:0];
        @(negedge clk);
        pwrite = 1'b0;
        penable = 1'b0;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[1:0] !== sb.direction)
            sb.report("direction readback", sb.direction, prdata[1:0]);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    function automatic stream_request_t make_request(h2ssm_pkg::state_code_t cur);
        stream_request_t r;
        int              pick;
        logic            force_it;
        r.frame_flags = 8'($urandom_range(0, 255));
        r.frame_flags[0] = ($urandom_range(0, 3) == 0);
        r.new_state = 3'($urandom_range(0, 7));
        r.ftype = 8'($urandom_range(0, 255));
        force_it = (cur == h2ssm_pkg::CODE_CLOSED) ? ($urandom_range(0, 9) < 8)
                                                   : ($urandom_range(0, 9) == 0);
        if (force_it)
            r.cmd = h2ssm_pkg::CMD_FORCE;
        else
        begin
            r.cmd = h2ssm_pkg::CMD_FRAME;
            pick = $urandom_range(0, 99);
            if (pick < 30)
                r.ftype = h2ssm_pkg::FT_DATA;
            else if (pick < 50)
                r.ftype = h2ssm_pkg::FT_HEADERS;
            else if (pick < 62)
                r.ftype = h2ssm_pkg::FT_PRIORITY;
            else if (pick < 70)
                r.ftype = h2ssm_pkg::FT_RST;
            else if (pick < 85)
                r.ftype = h2ssm_pkg::FT_WINDOW;
        end
        return r;
    endfunction

    initial
    begin
        logic [31:0]     dir_values[6];
        stream_request_t r;
        int              sent;
        int              burst_left;
        dir_values = '{32'h0000_0000, 32'hAAAA_AAA9, 32'h5555_5556, 32'hFFFF_FFFF,
                       32'h0000_0001, 32'h0000_0002};
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.cmd = h2ssm_pkg::CMD_FRAME;
        in_ch.ftype = h2ssm_pkg::FT_DATA;
        in_ch.frame_flags = 8'h00;
        in_ch.new_state = h2ssm_pkg::CODE_IDLE;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // direction not set after reset
        push_request(h2ssm_pkg::CMD_FRAME, h2ssm_pkg::FT_HEADERS, 8'h00, h2ssm_pkg::CODE_IDLE);
        push_request(h2ssm_pkg::CMD_FRAME, h2ssm_pkg::FT_DATA, 8'hFF, h2ssm_pkg::CODE_IDLE);
        push_request(h2ssm_pkg::CMD_FORCE, h2ssm_pkg::FT_DATA, 8'h00, h2ssm_pkg::CODE_HC_REM);
        push_request(h2ssm_pkg::CMD_FRAME, 8'hFF, 8'hFE, h2ssm_pkg::CODE_IDLE);
        push_request(h2ssm_pkg::CMD_FORCE, 8'hFF, 8'hFF, 3'd7);
        push_request(h2ssm_pkg::CMD_FRAME, h2ssm_pkg::FT_HEADERS, 8'h00, h2ssm_pkg::CODE_IDLE);
        push_request(h2ssm_pkg::CMD_FORCE, h2ssm_pkg::FT_DATA, 8'h00, h2ssm_pkg::CODE_IDLE);
        push_request(h2ssm_pkg::CMD_FRAME, h2ssm_pkg::FT_PRIORITY, 8'h00, h2ssm_pkg::CODE_IDLE);
        push_request(h2ssm_pkg::CMD_FRAME, h2ssm_pkg::FT_DATA, 8'h00, h2ssm_pkg::CODE_IDLE);
        wait_idle();
        set_direction(32'h0000_0002);
        push_request(h2ssm_pkg::CMD_FORCE, h2ssm_pkg::FT_DATA, 8'h00, h2ssm_pkg::CODE_RES_LOC);
        push_request(h2ssm_pkg::CMD_FRAME, h2ssm_pkg::FT_HEADERS, 8'h00, h2ssm_pkg::CODE_IDLE);
        push_request(h2ssm_pkg::CMD_FRAME, h2ssm_pkg::FT_DATA, 8'h01, h2ssm_pkg::CODE_IDLE);
        push_request(h2ssm_pkg::CMD_FORCE, h2ssm_pkg::FT_DATA, 8'h00, h2ssm_pkg::CODE_RES_REM);
        push_request(h2ssm_pkg::CMD_FRAME, h2ssm_pkg::FT_WINDOW, 8'h00, h2ssm_pkg::CODE_IDLE);
        push_request(h2ssm_pkg::CMD_FRAME, h2ssm_pkg::FT_RST, 8'h00, h2ssm_pkg::CODE_IDLE);
        wait_idle();
        set_direction(32'hFFFF_FFFF);
        push_request(h2ssm_pkg::CMD_FORCE, h2ssm_pkg::FT_DATA, 8'h00, h2ssm_pkg::CODE_OPEN);
        push_request(h2ssm_pkg::CMD_FRAME, 8'd4, 8'h01, h2ssm_pkg::CODE_IDLE);
        wait_idle();
        set_direction(32'h0000_0001);
        push_request(h2ssm_pkg::CMD_FORCE, h2ssm_pkg::FT_DATA, 8'h00, h2ssm_pkg::CODE_RES_REM);
        push_request(h2ssm_pkg::CMD_FRAME, h2ssm_pkg::FT_HEADERS, 8'h00, h2ssm_pkg::CODE_IDLE);
        push_request(h2ssm_pkg::CMD_FRAME, h2ssm_pkg::FT_DATA, 8'h01, h2ssm_pkg::CODE_IDLE);
        push_request(h2ssm_pkg::CMD_FORCE, h2ssm_pkg::FT_DATA, 8'h00, h2ssm_pkg::CODE_OPEN);
        push_request(h2ssm_pkg::CMD_FRAME, h2ssm_pkg::FT_DATA, 8'h81, h2ssm_pkg::CODE_IDLE);
        push_request(h2ssm_pkg::CMD_FRAME, h2ssm_pkg::FT_HEADERS, 8'h00, h2ssm_pkg::CODE_IDLE);
        wait_idle();

        burst_left = 0;
        foreach (dir_values[p])
        begin
            set_direction(dir_values[p]);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                @(negedge clk);
                if (burst_left == 0)
                begin
                    in_ch.valid = 1'b0;
                    repeat ($urandom_range(1, 6)) @(negedge clk);
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 8);
                end
                burst_left--;
                r = make_request(sb.stream_code);
                if (!(r.cmd == h2ssm_pkg::CMD_FRAME && sb.stream_code == h2ssm_pkg::CODE_CLOSED))
                    sent++;
                drive_request(r);
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
